// ----- rtl/charset_odometer_candidate_generator_core_macros.svh -----
// Assertion helpers shared by the core.
`ifndef CHARSET_ODOMETER_CANDIDATE_GENERATOR_CORE_MACROS_SVH
`define CHARSET_ODOMETER_CANDIDATE_GENERATOR_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define COCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define COCG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/cocg_pkg.sv -----
package cocg_pkg;

    localparam int NCLASS      = 4;
    localparam int DIG_W       = 7;
    localparam int POS_W       = 4;
    localparam int DV_W        = 8;
    localparam int NLEN_W      = 5;
    localparam int LEN_OUT_W   = 5;
    localparam int STAT_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_LEN_DEF = 16;
    localparam int Q_DEPTH     = 2;

    localparam logic [DIG_W-1:0] CLASS_LO [NCLASS] = '{7'd0, 7'd26, 7'd52, 7'd62};
    localparam logic [DIG_W-1:0] CLASS_HI [NCLASS] = '{7'd25, 7'd51, 7'd61, 7'd85};

    typedef enum logic [1:0] {
        OP_ADV = 2'd0,
        OP_WR  = 2'd1,
        OP_LEN = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_SUCCESS = 2'd0,
        STAT_DONE    = 2'd1,
        STAT_NOOPT   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER   = 2'd0,
        CFG_UPPER   = 2'd1,
        CFG_DIGITS  = 2'd2,
        CFG_SYMBOLS = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_ADV,
        BS_RESTORE,
        BS_EM_RD,
        BS_EM_OUT
    } bstate_t;

    // Decoded command as it travels through the queue.
    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic              pos_ok;
        logic              empty;
        logic [DIG_W-1:0]  val;
        logic [NLEN_W-1:0] nl;
        logic              fin;
    } cmd_t;

    typedef struct packed {
        logic             carry;
        logic [DIG_W-1:0] val;
    } step_t;

    function automatic logic [DIG_W-1:0] lowest_idx(logic [NCLASS-1:0] en);
        logic [DIG_W-1:0] r;
        logic             found;
        r     = '0;
        found = 1'b0;
        for (int i = 0; i < NCLASS; i++) begin
            if (!found && en[i]) begin
                found = 1'b1;
                r     = CLASS_LO[i];
            end
        end
        return r;
    endfunction

    function automatic logic [DIG_W-1:0] last_hi(logic [NCLASS-1:0] en);
        logic [DIG_W-1:0] r;
        r = '0;
        for (int i = 0; i < NCLASS; i++) begin
            if (en[i]) begin
                r = CLASS_HI[i];
            end
        end
        return r;
    endfunction

    // One odometer digit: next value, and whether it wrapped and carries.
    function automatic step_t step_digit(logic [NCLASS-1:0] en, logic ok,
                                         logic [DIG_W-1:0] v);
        step_t r;
        logic  found;
        logic  nfound;
        int    c;
        int    n;
        r.carry = 1'b0;
        r.val   = lowest_idx(en);
        found   = 1'b0;
        nfound  = 1'b0;
        c       = 0;
        n       = 0;
        for (int i = 0; i < NCLASS; i++) begin
            if (!found && en[i] && v >= CLASS_LO[i] && v <= CLASS_HI[i]) begin
                found = 1'b1;
                c     = i;
            end
        end
        for (int i = 0; i < NCLASS; i++) begin
            if (found && !nfound && i > c && en[i]) begin
                nfound = 1'b1;
                n      = i;
            end
        end
        if (ok && found) begin
            if (v < CLASS_HI[c]) begin
                r.val = v + DIG_W'(1);
            end else if (nfound) begin
                r.val = CLASS_LO[n];
            end else begin
                r.carry = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/cocg_ram.sv -----
module cocg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cocg_front.sv -----
module cocg_front #(
    parameter int MAX_LEN = cocg_pkg::MAX_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cocg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        command,
    input  logic [cocg_pkg::POS_W-1:0]        position,
    input  logic signed [cocg_pkg::DV_W-1:0]  digit_value,
    input  logic [cocg_pkg::NLEN_W-1:0]       new_length,
    input  logic                              mark_finished,
    input  logic                              q_ready,
    output logic                              push,
    output cocg_pkg::cmd_t                    push_cmd,
    output logic [cocg_pkg::NCLASS-1:0]       en
);

    logic [cocg_pkg::NCLASS-1:0] en_reg;
    logic [cocg_pkg::NCLASS-1:0] en_next;

    always_comb
    begin
        en_next = en_reg;
        if (cfg_wr_en)
        begin
            unique case (cocg_pkg::cfg_idx_t'(cfg_index))
                cocg_pkg::CFG_LOWER:   en_next[cocg_pkg::CFG_LOWER]   = cfg_data;
                cocg_pkg::CFG_UPPER:   en_next[cocg_pkg::CFG_UPPER]   = cfg_data;
                cocg_pkg::CFG_DIGITS:  en_next[cocg_pkg::CFG_DIGITS]  = cfg_data;
                cocg_pkg::CFG_SYMBOLS: en_next[cocg_pkg::CFG_SYMBOLS] = cfg_data;
                default:               en_next = en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
        end
        else
        begin
            en_reg <= en_next;
        end
    end

    assign en = en_reg;

    always_comb
    begin
        push_cmd.op     = cocg_pkg::op_t'(command);
        push_cmd.pos    = position;
        // writes past the top digit are dropped
        push_cmd.pos_ok = 32'(position) < MAX_LEN;
        push_cmd.empty  = digit_value[cocg_pkg::DV_W-1];
        push_cmd.val    = digit_value[cocg_pkg::DIG_W-1:0];
        push_cmd.nl     = new_length;
        push_cmd.fin    = mark_finished;
    end

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

endmodule

// ----- rtl/cocg_queue.sv -----
module cocg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cocg_pkg::cmd_t push_cmd,
    output logic           q_ready,
    input  logic           pop,
    output logic           head_valid,
    output cocg_pkg::cmd_t head
);

    localparam int QAW = (cocg_pkg::Q_DEPTH > 1) ? $clog2(cocg_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(cocg_pkg::Q_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_SLOT = QAW'(cocg_pkg::Q_DEPTH - 1);

    cocg_pkg::cmd_t entry_reg [cocg_pkg::Q_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign q_ready    = count_reg != QCW'(cocg_pkg::Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/cocg_back.sv -----
module cocg_back #(
    parameter int MAX_LEN = cocg_pkg::MAX_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [cocg_pkg::NCLASS-1:0]        en,
    input  logic                               head_valid,
    input  cocg_pkg::cmd_t                     head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cocg_pkg::STAT_W-1:0]        status,
    output logic [cocg_pkg::LEN_OUT_W-1:0]     length,
    output logic [cocg_pkg::DIG_W-1:0]         char_index,
    output logic                               last
);

    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_LEN - 1);

    cocg_pkg::bstate_t state_reg, state_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      len_reg, len_next;
    cocg_pkg::status_t  run_st_reg, run_st_next;
    cocg_pkg::status_t  st_reg, st_next;
    logic [MAX_LEN-1:0] vld_reg, vld_next;
    logic               out_valid_reg, out_valid_next;
    logic [cocg_pkg::STAT_W-1:0]    status_reg;
    logic [cocg_pkg::LEN_OUT_W-1:0] length_reg;
    logic [cocg_pkg::DIG_W-1:0]     char_reg;
    logic                           last_reg;

    logic                       ram_we;
    logic [PW-1:0]              ram_waddr;
    logic [cocg_pkg::DIG_W-1:0] ram_wdata;
    logic [PW-1:0]              ram_raddr;
    logic [cocg_pkg::DIG_W-1:0] ram_rdata;
    logic                       out_load;
    cocg_pkg::step_t            step;
    logic [LW-1:0]              walk_len;

    cocg_ram #(
        .WIDTH (cocg_pkg::DIG_W),
        .DEPTH (MAX_LEN),
        .AW    (PW)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign step     = cocg_pkg::step_digit(en, vld_reg[p_reg], ram_rdata);
    assign walk_len = LW'(p_reg) + LW'(1);
    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        run_st_next    = run_st_reg;
        st_next        = st_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = p_reg;
        ram_wdata      = step.val;
        ram_raddr      = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cocg_pkg::BS_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    st_next    = run_st_reg;
                    state_next = cocg_pkg::BS_EM_RD;
                    unique case (head.op)
                        cocg_pkg::OP_ADV:
                        begin
                            if (en == '0)
                            begin
                                st_next = cocg_pkg::STAT_NOOPT;
                            end
                            else if (run_st_reg != cocg_pkg::STAT_SUCCESS)
                            begin
                                st_next = cocg_pkg::STAT_DONE;
                            end
                            else
                            begin
                                p_next     = '0;
                                ram_raddr  = '0;
                                state_next = cocg_pkg::BS_ADV;
                            end
                        end
                        cocg_pkg::OP_WR:
                        begin
                            if (head.pos_ok)
                            begin
                                vld_next[PW'(head.pos)] = !head.empty;
                                ram_we    = !head.empty;
                                ram_waddr = PW'(head.pos);
                                ram_wdata = head.val;
                            end
                        end
                        cocg_pkg::OP_LEN:
                        begin
                            len_next    = (32'(head.nl) > MAX_LEN) ? LW'(MAX_LEN)
                                                                   : LW'(head.nl);
                            run_st_next = head.fin ? cocg_pkg::STAT_DONE
                                                   : cocg_pkg::STAT_SUCCESS;
                            st_next     = run_st_next;
                        end
                        default:
                        begin
                            st_next = run_st_reg;
                        end
                    endcase
                end
            end

            // one digit per cycle; the read of the next digit overlaps the write
            cocg_pkg::BS_ADV:
            begin
                ram_we    = 1'b1;
                ram_raddr = p_reg + PW'(1);
                if (!step.carry)
                begin
                    vld_next[p_reg] = 1'b1;
                    if (walk_len > len_reg)
                    begin
                        len_next = walk_len;
                    end
                    st_next    = cocg_pkg::STAT_SUCCESS;
                    state_next = cocg_pkg::BS_EM_RD;
                end
                else if (p_reg == LAST_POS)
                begin
                    run_st_next = cocg_pkg::STAT_DONE;
                    st_next     = cocg_pkg::STAT_DONE;
                    p_next      = '0;
                    state_next  = cocg_pkg::BS_RESTORE;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end

            // full wrap: every digit held the top index of the last enabled class
            cocg_pkg::BS_RESTORE:
            begin
                ram_we    = 1'b1;
                ram_wdata = cocg_pkg::last_hi(en);
                if (p_reg == LAST_POS)
                begin
                    state_next = cocg_pkg::BS_EM_RD;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end

            cocg_pkg::BS_EM_RD:
            begin
                idx_next   = (len_reg == '0) ? '0 : PW'(len_reg - LW'(1));
                ram_raddr  = idx_next;
                state_next = cocg_pkg::BS_EM_OUT;
            end

            cocg_pkg::BS_EM_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = cocg_pkg::BS_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg - PW'(1);
                        ram_raddr = idx_next;
                    end
                end
            end

            default:
            begin
                state_next = cocg_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cocg_pkg::BS_IDLE;
            p_reg         <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            run_st_reg    <= cocg_pkg::STAT_SUCCESS;
            st_reg        <= cocg_pkg::STAT_SUCCESS;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            run_st_reg    <= run_st_next;
            st_reg        <= st_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cocg_pkg::BS_EM_OUT && out_load)
        begin
            status_reg <= st_reg;
            length_reg <= cocg_pkg::LEN_OUT_W'(len_reg);
            char_reg   <= (len_reg != '0 && vld_reg[idx_reg]) ? ram_rdata : '0;
            last_reg   <= idx_reg == '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign length     = length_reg;
    assign char_index = char_reg;
    assign last       = last_reg;

endmodule

// ----- rtl/charset_odometer_candidate_generator_core.sv -----
// Each command passes through the input queue to the single back-end sequencer, which
// handles one command at a time: an advance steps through the digits it visits (all of
// them again on a full wrap), then the candidate is read out through the one read port
// of the digit RAM a character at a time. The queue takes new commands while the
// sequencer is busy, until it is full.
// Reset (rst_n, async low): class enables off, all digits empty, length 0, status success.
`include "charset_odometer_candidate_generator_core_macros.svh"

module charset_odometer_candidate_generator_core #(
    parameter int MAX_LEN = cocg_pkg::MAX_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cocg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        command,
    input  logic [cocg_pkg::POS_W-1:0]        position,
    input  logic signed [cocg_pkg::DV_W-1:0]  digit_value,
    input  logic [cocg_pkg::NLEN_W-1:0]       new_length,
    input  logic                              mark_finished,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cocg_pkg::STAT_W-1:0]       status,
    output logic [cocg_pkg::LEN_OUT_W-1:0]    length,
    output logic [cocg_pkg::DIG_W-1:0]        char_index,
    output logic                              last
);

    logic                        q_ready;
    logic                        push;
    cocg_pkg::cmd_t              push_cmd;
    logic [cocg_pkg::NCLASS-1:0] en;
    logic                        pop;
    logic                        head_valid;
    cocg_pkg::cmd_t              head;

    cocg_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .position      (position),
        .digit_value   (digit_value),
        .new_length    (new_length),
        .mark_finished (mark_finished),
        .q_ready       (q_ready),
        .push          (push),
        .push_cmd      (push_cmd),
        .en            (en)
    );

    cocg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cocg_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .length     (length),
        .char_index (char_index),
        .last       (last)
    );

    `COCG_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")
    `COCG_ASSERT(a_push_lands, (in_valid && in_ready) |=> head_valid, "accepted item lost")
    `COCG_ASSERT(a_pop_spacing, pop |=> !pop, "back end took two items in a row")

endmodule

// ----- verif/tb_charset_odometer_candidate_generator_core.sv -----
module tb_charset_odometer_candidate_generator_core;
    import cocg_pkg::*;

    localparam int MAX_DIGITS    = MAX_LEN_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 22;
    localparam int NUM_PHASES    = 7;
    localparam longint TIMEOUT   = 64'd10_000_000;

    typedef struct packed {
        op_t                      op;
        logic [POS_W-1:0]         pos;
        logic signed [DV_W-1:0]   dv;
        logic [NLEN_W-1:0]        nl;
        logic                     fin;
    } item_t;

    typedef struct packed {
        status_t                  st;
        logic [LEN_OUT_W-1:0]     len;
        logic [DIG_W-1:0]         ch;
        logic                     last;
    } char_t;

    // Tracks the odometer state and the characters each command should emit.
    class candidate_tracker;
        bit [NCLASS-1:0] class_en;
        bit [DIG_W-1:0]  digit_val [MAX_DIGITS];
        bit              digit_set [MAX_DIGITS];
        int              cand_len;
        status_t         run_st;
        char_t           expected_chars[$];
        int unsigned     error_cnt;
        int unsigned     chars_checked;
        int unsigned     wraps;

        function new();
            class_en      = '0;
            cand_len      = 0;
            run_st        = STAT_SUCCESS;
            error_cnt     = 0;
            chars_checked = 0;
            wraps         = 0;
        endfunction

        function status_t advance_odometer();
            bit [DIG_W-1:0] val [MAX_DIGITS];
            bit             ok [MAX_DIGITS];
            bit [DIG_W-1:0] low;
            bit             have_low;
            bit             settled;
            int             cls;
            int             nxt;
            int             top;
            if (class_en == '0)
                return STAT_NOOPT;
            if (run_st != STAT_SUCCESS)
                return STAT_DONE;
            val      = digit_val;
            ok       = digit_set;
            low      = '0;
            have_low = 1'b0;
            for (int c = 0; c < NCLASS; c++)
            begin
                if (class_en[c] && !have_low)
                begin
                    low      = CLASS_LO[c];
                    have_low = 1'b1;
                end
            end
            settled = 1'b0;
            top     = 0;
            for (int p = 0; p < MAX_DIGITS; p++)
            begin
                if (!settled)
                begin
                    cls = -1;
                    for (int c = NCLASS - 1; c >= 0; c--)
                        if (class_en[c] && val[p] >= CLASS_LO[c] && val[p] <= CLASS_HI[c])
                            cls = c;
                    nxt = -1;
                    if (cls >= 0)
                        for (int c = NCLASS - 1; c > cls; c--)
                            if (class_en[c])
                                nxt = c;
                    top     = p;
                    settled = 1'b1;
                    if (!ok[p])
                    begin
                        ok[p]  = 1'b1;
                        val[p] = low;
                    end
                    else if (cls < 0)
                        val[p] = low;
                    else if (val[p] < CLASS_HI[cls])
                        val[p] = val[p] + 1'b1;
                    else if (nxt >= 0)
                        val[p] = CLASS_LO[nxt];
                    else
                    begin
                        // wrapped: carry into the next position
                        val[p]  = low;
                        settled = 1'b0;
                    end
                end
            end
            if (!settled)
            begin
                run_st = STAT_DONE;
                wraps++;
                return STAT_DONE;
            end
            digit_val = val;
            digit_set = ok;
            if (top + 1 > cand_len)
                cand_len = top + 1;
            return STAT_SUCCESS;
        endfunction

        function void take_command(item_t it);
            status_t st;
            char_t   exp_ch;
            int      shown;
            int      cnt;
            st = run_st;
            case (it.op)
                OP_ADV:
                    st = advance_odometer();
                OP_WR:
                begin
                    if (it.pos < MAX_DIGITS)
                    begin
                        digit_set[it.pos] = !it.dv[DV_W-1];
                        digit_val[it.pos] = it.dv[DV_W-1] ? '0 : it.dv[DIG_W-1:0];
                    end
                    st = run_st;
                end
                OP_LEN:
                begin
                    cand_len = (it.nl > MAX_DIGITS) ? MAX_DIGITS : int'(it.nl);
                    run_st   = it.fin ? STAT_DONE : STAT_SUCCESS;
                    st       = run_st;
                end
                default: ;
            endcase
            shown = (cand_len > MAX_DIGITS) ? MAX_DIGITS : cand_len;
            cnt   = (shown == 0) ? 1 : shown;
            for (int k = 0; k < cnt; k++)
            begin
                exp_ch.st   = st;
                exp_ch.len  = LEN_OUT_W'(cand_len);
                exp_ch.ch   = (shown != 0 && digit_set[shown-1-k]) ? digit_val[shown-1-k]
                                                                   : '0;
                exp_ch.last = (k == cnt - 1);
                expected_chars.push_back(exp_ch);
            end
        endfunction

        function void check_char(logic [STAT_W-1:0] st, logic [LEN_OUT_W-1:0] len,
                                 logic [DIG_W-1:0] ch, logic lst);
            char_t exp_ch;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("result %0d with nothing pending: %s %0d %0d %0d %0d",
                             chars_checked, "status/length/char/last", st, len, ch, lst);
            end
            else
            begin
                exp_ch = expected_chars.pop_front();
                if (st !== exp_ch.st || len !== exp_ch.len || ch !== exp_ch.ch
                    || lst !== exp_ch.last)
                begin
                    error_cnt++;
                    if (error_cnt <= 10)
                    begin
                        $display("result %0d wrong: exp st %0d len %0d ch %0d last %0d,",
                                 chars_checked, exp_ch.st, exp_ch.len, exp_ch.ch,
                                 exp_ch.last);
                        $display("    got st %0d len %0d ch %0d last %0d",
                                 st, len, ch, lst);
                    end
                end
            end
        endfunction
    endclass

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic                    cfg_data      = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_ready;
    logic [1:0]              command       = '0;
    logic [POS_W-1:0]        position      = '0;
    logic signed [DV_W-1:0]  digit_value   = '0;
    logic [NLEN_W-1:0]       new_length    = '0;
    logic                    mark_finished = 1'b0;
    logic                    out_valid;
    logic                    out_ready     = 1'b0;
    logic [STAT_W-1:0]       status;
    logic [LEN_OUT_W-1:0]    length;
    logic [DIG_W-1:0]        char_index;
    logic                    last;

    candidate_tracker sb = new();
    item_t            batch[$];
    bit               steady_send   = 1'b0;
    int unsigned      items_sent    = 0;
    int unsigned      settings_used = 0;

    charset_odometer_candidate_generator_core #(
        .MAX_LEN(MAX_DIGITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .position     (position),
        .digit_value  (digit_value),
        .new_length   (new_length),
        .mark_finished(mark_finished),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .length       (length),
        .char_index   (char_index),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(status, length, char_index, last);
    end

    // Receiver: bursts of readiness broken by stalls, now and then a long open stretch.
    initial
    begin
        int burst;
        int stall;
        int r;
        @(posedge clk);
        forever
        begin
            r     = $urandom_range(0, 99);
            burst = (r < 10) ? 200 : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 60)
                stall = $urandom_range(1, 2);
            else if (r < 92)
                stall = $urandom_range(3, 6);
            else
                stall = $urandom_range(15, 40);
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [DV_W-1:0] pick_digit();
        int r;
        int c;
        r = $urandom_range(0, 9);
        c = $urandom_range(0, NCLASS - 1);
        case (r)
            0:       return -8'sd1;
            1:       return DV_W'($urandom_range(0, 255));
            2:       return DV_W'($urandom_range(86, 127));
            3:       return DV_W'(CLASS_LO[c]);
            default: return DV_W'(CLASS_HI[c] - $urandom_range(0, 2));
        endcase
    endfunction

    function automatic void add_item(op_t op, int pos, logic signed [DV_W-1:0] dv, int nl,
                                     bit fin);
        item_t it;
        it.op  = op;
        it.pos = POS_W'(pos);
        it.dv  = dv;
        it.nl  = NLEN_W'(nl);
        it.fin = fin;
        batch.push_back(it);
    endfunction

    // Random filler for the fields a command does not use.
    function automatic void add_cmd(op_t op);
        add_item(op, $urandom_range(0, 15), DV_W'($urandom_range(0, 255)),
                 $urandom_range(0, 31), 1'($urandom_range(0, 1)));
    endfunction

    task automatic run_batch();
        int gap;
        int r;
        for (int i = 0; i < batch.size(); i++)
        begin
            in_valid      <= 1'b1;
            command       <= batch[i].op;
            position      <= batch[i].pos;
            digit_value   <= batch[i].dv;
            new_length    <= batch[i].nl;
            mark_finished <= batch[i].fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sb.take_command(batch[i]);
            items_sent++;
            r = $urandom_range(0, 99);
            if (steady_send || r < 50)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 96)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(15, 40);
            if (gap > 0 || i == batch.size() - 1)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        batch.delete();
    endtask

    task automatic wait_results(int extra);
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_classes(bit [NCLASS-1:0] en);
        for (int i = 0; i < NCLASS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= en[i];
            @(posedge clk);
            sb.class_en[i] = en[i];
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic build_random_phase(int n);
        int             r;
        int             nl;
        logic [DIG_W-1:0] top;
        while (batch.size() < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                // resume: preset length and a few digits, then step
                r = $urandom_range(0, 99);
                nl = (r < 70) ? $urandom_range(0, 4) :
                     (r < 90) ? $urandom_range(5, 16) : $urandom_range(17, 31);
                add_item(OP_LEN, $urandom_range(0, 15), DV_W'($urandom_range(0, 255)), nl,
                         $urandom_range(0, 9) == 0);
                repeat ($urandom_range(0, 3))
                    add_item(OP_WR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 3),
                             pick_digit(), $urandom_range(0, 31),
                             1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 6))
                    add_cmd(OP_ADV);
            end
            else if (r < 75)
            begin
                repeat ($urandom_range(1, 8))
                    add_cmd(OP_ADV);
            end
            else if (r < 80)
            begin
                // every digit at the top of the last enabled class: one step, then overflow
                top = CLASS_HI[NCLASS-1];
                for (int c = 0; c < NCLASS; c++)
                    if (sb.class_en[c])
                        top = CLASS_HI[c];
                for (int p = MAX_DIGITS - 1; p >= 0; p--)
                    add_item(OP_WR, p, (p == 0) ? DV_W'(top - 1'b1) : DV_W'(top),
                             $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                add_item(OP_LEN, $urandom_range(0, 15), DV_W'($urandom_range(0, 255)),
                         $urandom_range(16, 31), 1'b0);
                add_cmd(OP_ADV);
                add_cmd(OP_ADV);
            end
            else
                add_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), pick_digit(),
                         $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        bit [NCLASS-1:0] phase_en [NUM_PHASES];
        phase_en = '{4'b0100, 4'b1111, 4'b0000, 4'b1000, 4'b0011, 4'b0000, 4'b0000};
        for (int i = 5; i < NUM_PHASES; i++)
            phase_en[i] = NCLASS'($urandom_range(1, 15));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no class enabled, empty candidate
        add_cmd(OP_ADV);
        add_cmd(OP_NOP);
        run_batch();
        wait_results(SETTLE_CYCLES);

        // lower letters and symbols: class jump, stray digit, overflow, resume
        write_classes(4'b1001);
        add_cmd(OP_ADV);
        add_item(OP_WR, 0, 8'sd25, 0, 1'b0);
        add_cmd(OP_ADV);
        add_item(OP_WR, 0, 8'sd40, 31, 1'b1);
        add_cmd(OP_ADV);
        for (int p = MAX_DIGITS - 1; p >= 0; p--)
            add_item(OP_WR, p, 8'sd85, 0, 1'b0);
        add_item(OP_LEN, 0, 8'sd0, 31, 1'b0);
        add_cmd(OP_ADV);
        add_cmd(OP_ADV);
        add_item(OP_WR, 3, -8'sd1, 16, 1'b0);
        add_item(OP_LEN, 15, 8'sd127, 4, 1'b0);
        run_batch();
        wait_results(SETTLE_CYCLES);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_classes(phase_en[ph]);
            steady_send = ($urandom_range(0, 3) == 0);
            build_random_phase(PHASE_ITEMS);
            run_batch();
            wait_results(SETTLE_CYCLES);
        end
        steady_send = 1'b0;

        wait_results(40);
        $display("Ran %0d commands over %0d class settings, checked %0d characters",
                 items_sent, settings_used, sb.chars_checked);
        $display("Odometer overflowed past its top digit %0d times", sb.wraps);
        if (sb.error_cnt == 0 && sb.expected_chars.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
